### src/assert_macros.svh
// Assertion macros used by the cache store controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");
// Next-cycle implication, disabled during reset
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");
`else
`define AST_IMP(lbl, clk, rst_n, ante, cons)
`define AST_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/sacl_pkg.sv
// Shared types, constants and helpers of the cache store
package sacl_pkg;

    localparam int SETS_DEF       = 16;
    localparam int WAYS_DEF       = 4;
    localparam int LINE_BYTES_DEF = 8;
    localparam int ADDR_W         = 32;
    localparam int WAY_W          = 4;

    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_INSTALL = 3'd2;
    localparam logic [2:0] KIND_UPDATE  = 3'd3;
    localparam logic [2:0] KIND_INVAL   = 3'd4;

    localparam logic CFG_HIT_LAT  = 1'b0;
    localparam logic CFG_MISS_LAT = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [7:0]  byte_value;
        logic [63:0] line_value;
        logic        line_dirty;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [7:0]  read_byte;
        logic [15:0] latency;
        logic        evicted_valid;
        logic        evicted_dirty;
        logic [31:0] evicted_address;
        logic [63:0] evicted_line;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             rd;
        logic [WAY_W-1:0] way;
        logic             commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic int floor_log2(input int v);
        int r;
        int x;
        r = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            r = r + 1;
        end
        return r;
    endfunction

endpackage

### src/sacl_ctrl.sv
// Sequencing state machine of the cache store
`include "assert_macros.svh"
module sacl_ctrl #(
    parameter int WAYS = sacl_pkg::WAYS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sacl_pkg::t_sts i_sts,
    output sacl_pkg::t_cmd o_cmd
);
    import sacl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    logic [1:0]       r_state, n_state;
    logic [WAY_W-1:0] r_way, n_way;
    logic             in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // Step through accept, way scan, last compare and commit
    always_comb begin
        n_state      = r_state;
        n_way        = r_way;
        o_cmd        = '0;
        o_cmd.way    = r_way;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    n_way      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (r_way == LAST_WAY) begin
                    n_state = S_DRAIN;
                end else begin
                    n_way = r_way + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_way   <= '0;
        end else begin
            r_state <= n_state;
            r_way   <= n_way;
        end
    end

    `AST_NXT(a_acc_scan, i_clk, i_rst_n, in_acc, (r_state == S_SCAN) && (r_way == '0))
    `AST_IMP(a_commit_free, i_clk, i_rst_n, o_cmd.commit, i_sts.out_free)
    `AST_IMP(a_way_range, i_clk, i_rst_n, r_state == S_SCAN, r_way <= LAST_WAY)

endmodule

### src/sacl_dp.sv
// Datapath of the cache store: request, way scan, entry memory and result
module sacl_dp #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int LINE_BYTES = sacl_pkg::LINE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacl_pkg::t_cmd i_cmd,
    output sacl_pkg::t_sts o_sts,
    input  sacl_pkg::t_req i_in_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output sacl_pkg::t_rsp o_out_data
);
    import sacl_pkg::*;

    localparam int OFF_W     = floor_log2(LINE_BYTES);
    localparam int SET_W     = floor_log2(SETS);
    localparam int TAG_W     = ADDR_W - OFF_W - SET_W;
    localparam int OFF_IDX_W = (OFF_W > 0) ? OFF_W : 1;
    localparam int ENTRIES   = SETS * WAYS;
    localparam int EIDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [31:0] SET_MASK = (32'd1 << SET_W) - 32'd1;
    localparam logic [OFF_IDX_W-1:0] OFF_MASK = OFF_IDX_W'((1 << OFF_W) - 1);
    localparam logic [63:0] LINE_MASK =
        (LINE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * LINE_BYTES)) - 64'd1);

    // Entry memory, one entry per way of each set
    logic [TAG_W-1:0] mem_tag   [ENTRIES];
    logic             mem_dirty [ENTRIES];
    logic [31:0]      mem_stamp [ENTRIES];
    logic [63:0]      mem_data  [ENTRIES];

    logic [ENTRIES-1:0] r_valid;
    logic [7:0]         r_hit_lat;
    logic [15:0]        r_miss_lat;
    logic [31:0]        r_cnt;
    t_req               r_req;

    logic [TAG_W-1:0] r_rd_tag;
    logic             r_rd_dirty;
    logic [31:0]      r_rd_stamp;
    logic [63:0]      r_rd_data;
    logic             r_ev_v;
    logic [WAY_W-1:0] r_ev_way;

    logic             r_h_v;
    logic [WAY_W-1:0] r_h_way;
    logic             r_h_dirty;
    logic [31:0]      r_h_stamp;
    logic [63:0]      r_h_data;
    logic             r_i_v;
    logic [WAY_W-1:0] r_i_way;
    logic [WAY_W-1:0] r_m_way;
    logic [TAG_W-1:0] r_m_tag;
    logic             r_m_dirty;
    logic [31:0]      r_m_stamp;
    logic [63:0]      r_m_data;

    logic   r_out_v;
    t_rsp   r_out;

    logic [31:0]          set32;
    logic [TAG_W-1:0]     req_tag;
    logic [OFF_IDX_W-1:0] off;
    logic [EIDX_W-1:0]    rd_idx, ev_idx, wr_idx;
    logic                 ev_valid;
    logic                 cnt_inc;

    logic             wr_en;
    logic [WAY_W-1:0] wr_way;
    logic             wr_dirty;
    logic [TAG_W-1:0] wr_tag;
    logic [31:0]      wr_stamp;
    logic [63:0]      wr_data;
    logic             vset, vclr;
    t_rsp             n_out;
    logic [63:0]      byte_sh;
    logic [63:0]      byte_mask;
    logic [TAG_W-1:0] ev_tag;

    assign set32   = (r_req.address >> OFF_W) & SET_MASK;
    assign req_tag = TAG_W'(r_req.address >> (OFF_W + SET_W));
    assign off     = OFF_IDX_W'(r_req.address) & OFF_MASK;
    assign rd_idx  = EIDX_W'(set32 * WAYS + 32'(i_cmd.way));
    assign ev_idx  = EIDX_W'(set32 * WAYS + 32'(r_ev_way));
    assign wr_idx  = EIDX_W'(set32 * WAYS + 32'(wr_way));
    assign ev_valid = r_valid[ev_idx];
    assign cnt_inc = (i_in_data.kind == KIND_READ) || (i_in_data.kind == KIND_WRITE)
                  || (i_in_data.kind == KIND_INSTALL);

    assign o_sts.out_free = !r_out_v || !i_out_stall;
    assign o_out_valid    = r_out_v;
    assign o_out_data     = r_out;

    // Hold configuration, use counter and the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_lat  <= 8'd1;
            r_miss_lat <= 16'd100;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_HIT_LAT)) begin
                r_hit_lat <= i_cfg_data[7:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_MISS_LAT)) begin
                r_miss_lat <= i_cfg_data;
            end
            if (i_cmd.load && cnt_inc) begin
                r_cnt <= r_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    // Read one way per cycle; write the chosen entry at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_tag   <= mem_tag[rd_idx];
            r_rd_dirty <= mem_dirty[rd_idx];
            r_rd_stamp <= mem_stamp[rd_idx];
            r_rd_data  <= mem_data[rd_idx];
        end
        if (wr_en) begin
            mem_tag[wr_idx]   <= wr_tag;
            mem_dirty[wr_idx] <= wr_dirty;
            mem_stamp[wr_idx] <= wr_stamp;
            mem_data[wr_idx]  <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_v <= 1'b0;
        end else begin
            r_ev_v <= i_cmd.rd;
        end
        r_ev_way <= i_cmd.way;
    end

    // Track first hit, first free way and oldest stamp over the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
        end else if (r_ev_v) begin
            if (ev_valid && (r_rd_tag == req_tag) && !r_h_v) begin
                r_h_v     <= 1'b1;
                r_h_way   <= r_ev_way;
                r_h_dirty <= r_rd_dirty;
                r_h_stamp <= r_rd_stamp;
                r_h_data  <= r_rd_data;
            end
            if (!ev_valid && !r_i_v) begin
                r_i_v   <= 1'b1;
                r_i_way <= r_ev_way;
            end
            if ((r_ev_way == '0) || (r_rd_stamp < r_m_stamp)) begin
                r_m_way   <= r_ev_way;
                r_m_tag   <= r_rd_tag;
                r_m_dirty <= r_rd_dirty;
                r_m_stamp <= r_rd_stamp;
                r_m_data  <= r_rd_data;
            end
        end
    end

    // Build the result and the entry update for the request kind
    always_comb begin
        byte_sh   = r_h_data >> {off, 3'b000};
        byte_mask = 64'hFF << {off, 3'b000};
        ev_tag    = r_h_v ? req_tag : r_m_tag;
        n_out     = '0;
        wr_en     = 1'b0;
        wr_way    = r_h_way;
        wr_tag    = req_tag;
        wr_dirty  = r_h_dirty;
        wr_stamp  = r_cnt;
        wr_data   = r_h_data;
        vset      = 1'b0;
        vclr      = 1'b0;
        case (r_req.kind)
            KIND_READ: begin
                n_out.hit     = r_h_v;
                n_out.latency = r_h_v ? {8'd0, r_hit_lat} : r_miss_lat;
                if (r_h_v) begin
                    n_out.read_byte = byte_sh[7:0];
                    wr_en           = 1'b1;
                end
            end
            KIND_WRITE: begin
                n_out.hit = r_h_v;
                if (r_h_v) begin
                    n_out.latency = {8'd0, r_hit_lat};
                    wr_en         = 1'b1;
                    wr_dirty      = 1'b1;
                    wr_data       = (r_h_data & ~byte_mask)
                                  | (64'(r_req.byte_value) << {off, 3'b000});
                end
            end
            KIND_INSTALL: begin
                wr_en    = 1'b1;
                vset     = 1'b1;
                wr_way   = r_i_v ? r_i_way : r_m_way;
                wr_dirty = r_req.line_dirty;
                wr_data  = r_req.line_value & LINE_MASK;
                if (!r_i_v) begin
                    n_out.evicted_valid   = 1'b1;
                    n_out.evicted_dirty   = r_m_dirty;
                    n_out.evicted_address = (32'(r_m_tag) << (OFF_W + SET_W))
                                          | (set32 << OFF_W);
                    n_out.evicted_line    = r_m_data;
                end
            end
            KIND_UPDATE: begin
                n_out.hit = r_h_v;
                if (r_h_v) begin
                    wr_en    = 1'b1;
                    wr_dirty = 1'b1;
                    wr_stamp = r_h_stamp;
                    wr_data  = r_req.line_value & LINE_MASK;
                end
            end
            KIND_INVAL: begin
                n_out.hit = r_h_v;
                if (r_h_v) begin
                    vclr                  = 1'b1;
                    n_out.evicted_valid   = 1'b1;
                    n_out.evicted_dirty   = r_h_dirty;
                    n_out.evicted_address = (32'(ev_tag) << (OFF_W + SET_W))
                                          | (set32 << OFF_W);
                    n_out.evicted_line    = r_h_data;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
        if (!i_cmd.commit) begin
            wr_en = 1'b0;
            vset  = 1'b0;
            vclr  = 1'b0;
        end
    end

    // Valid bits in flops, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (vset) begin
            r_valid[wr_idx] <= 1'b1;
        end else if (vclr) begin
            r_valid[wr_idx] <= 1'b0;
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

endmodule

### src/set_assoc_cache_lru.sv
// Top level of the set-associative cache store with timestamp LRU replacement
//
// One transaction at a time: a request is taken when the block is idle, then
// the ways of its set are read from the entry memory one per cycle, and the
// result is registered. No new request is taken until the last is committed;
// the entry memory has a single read port scanned way by way, and a stalled
// result holds the next commit. Valid bits are flops cleared by reset, so no
// clearing pass is needed. Configuration: index 0 hit latency, 1 miss latency.
module set_assoc_cache_lru #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int LINE_BYTES = sacl_pkg::LINE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sacl_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sacl_pkg::t_rsp o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    import sacl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sacl_ctrl #(
        .WAYS(WAYS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sacl_dp #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
